[hw/rtl/joint_velocity_scaler_assert.svh]
// ============================================================================
// Joint velocity scaler assertion macros
// Short forms for clocked assertions with synchronous active-low reset.
// ============================================================================
`ifndef JOINT_VELOCITY_SCALER_ASSERT_SVH
`define JOINT_VELOCITY_SCALER_ASSERT_SVH

// Same-cycle implication
`define JVS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define JVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/jvs_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// jvs_pkg
// Shared widths, register indexes, reset values and bus types of the
// joint velocity scaler.
// ============================================================================
package jvs_pkg;

    localparam int NJ              = 6;   // joints
    localparam int ANGLE_W         = 16;  // Q4.12 angle / speed
    localparam int ERR_W           = ANGLE_W + 1;
    localparam int MAG_W           = ANGLE_W;     // |err| <= 65535
    localparam int SPD_CFG_W       = 15;  // max_speed, deadband
    localparam int SPEED_W         = 16;
    localparam int PROD_W          = MAG_W + SPD_CFG_W;
    localparam int QUO_W           = SPD_CFG_W;   // quotient <= max_speed if divisor > 0
    localparam int DIV_BITS_PER_STAGE = 3;
    localparam int DIV_STAGES      = (QUO_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = ANGLE_W;

    // Reset values in Q.F, rounded, limited to the register range
    localparam int     ANGLE_FRAC_BITS = 12;
    localparam longint SPD_CFG_MAX     = (longint'(1) << SPD_CFG_W) - 1;
    localparam longint MAX_SPEED_RAW   = ((longint'(314) << ANGLE_FRAC_BITS) + 50) / 100;
    localparam longint DEADBAND_RAW    = ((longint'(2) << ANGLE_FRAC_BITS) + 50) / 100;
    localparam logic [SPD_CFG_W-1:0] MAX_SPEED_RST =
        (MAX_SPEED_RAW > SPD_CFG_MAX) ? SPD_CFG_W'(SPD_CFG_MAX) : SPD_CFG_W'(MAX_SPEED_RAW);
    localparam logic [SPD_CFG_W-1:0] DEADBAND_RST =
        (DEADBAND_RAW > SPD_CFG_MAX) ? SPD_CFG_W'(SPD_CFG_MAX) : SPD_CFG_W'(DEADBAND_RAW);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GOAL_ANGLE_0 = 3'd0,
        CFG_GOAL_ANGLE_1 = 3'd1,
        CFG_GOAL_ANGLE_2 = 3'd2,
        CFG_GOAL_ANGLE_3 = 3'd3,
        CFG_GOAL_ANGLE_4 = 3'd4,
        CFG_GOAL_ANGLE_5 = 3'd5,
        CFG_MAX_SPEED    = 3'd6,
        CFG_DEADBAND     = 3'd7
    } cfg_index_t;

    typedef logic [NJ-1:0][ANGLE_W-1:0] angle_vec_t;
    typedef logic [NJ-1:0][PROD_W-1:0]  rem_vec_t;
    typedef logic [NJ-1:0][QUO_W-1:0]   quo_vec_t;
    typedef logic [NJ-1:0][SPEED_W-1:0] speed_vec_t;

    typedef struct packed {
        angle_vec_t             goal;
        logic [SPD_CFG_W-1:0]   max_speed;
        logic [SPD_CFG_W-1:0]   deadband;
    } cfg_t;

    // Per-transaction control that rides along the divider
    typedef struct packed {
        logic [NJ-1:0]    live;     // |err| above deadband
        logic [NJ-1:0]    neg;      // error sign
        logic [MAG_W-1:0] divisor;  // largest |err|
    } div_ctl_t;

endpackage

[hw/rtl/jvs_cfg_regs.sv]
`timescale 1ns / 1ps
// ============================================================================
// jvs_cfg_regs
// Goal angles, max speed and deadband registers behind a plain write port.
// ============================================================================
module jvs_cfg_regs
    import jvs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output cfg_t                  cfg_o
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                CFG_GOAL_ANGLE_0: cfg_next.goal[0] = cfg_wr_data[ANGLE_W-1:0];
                CFG_GOAL_ANGLE_1: cfg_next.goal[1] = cfg_wr_data[ANGLE_W-1:0];
                CFG_GOAL_ANGLE_2: cfg_next.goal[2] = cfg_wr_data[ANGLE_W-1:0];
                CFG_GOAL_ANGLE_3: cfg_next.goal[3] = cfg_wr_data[ANGLE_W-1:0];
                CFG_GOAL_ANGLE_4: cfg_next.goal[4] = cfg_wr_data[ANGLE_W-1:0];
                CFG_GOAL_ANGLE_5: cfg_next.goal[5] = cfg_wr_data[ANGLE_W-1:0];
                CFG_MAX_SPEED:    cfg_next.max_speed = cfg_wr_data[SPD_CFG_W-1:0];
                CFG_DEADBAND:     cfg_next.deadband  = cfg_wr_data[SPD_CFG_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.goal      <= '0;
            cfg_reg.max_speed <= MAX_SPEED_RST;
            cfg_reg.deadband  <= DEADBAND_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_o = cfg_reg;

endmodule

[hw/rtl/jvs_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// jvs_front
// Two pipeline stages: joint errors and magnitudes, then largest error,
// scaled products and deadband test.
// ============================================================================
module jvs_front
    import jvs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       adv,
    input  logic       in_valid,
    input  angle_vec_t in_angle,
    input  cfg_t       cfg,
    output logic       out_valid,
    output rem_vec_t   out_prod,
    output div_ctl_t   out_ctl
);

    function automatic logic [MAG_W-1:0] max_mag(input logic [MAG_W-1:0] a,
                                                  input logic [MAG_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // Stage 1 registers
    logic                         valid1_reg;
    logic [NJ-1:0][MAG_W-1:0]     mag1_reg;
    logic [NJ-1:0][MAG_W-1:0]     mag1_next;
    logic [NJ-1:0]                neg1_reg;
    logic [NJ-1:0]                neg1_next;

    // Stage 2 registers
    logic                         valid2_reg;
    rem_vec_t                     prod2_reg;
    rem_vec_t                     prod2_next;
    div_ctl_t                     ctl2_reg;
    div_ctl_t                     ctl2_next;

    logic [ERR_W-1:0]             err   [NJ];
    logic [ERR_W-1:0]             nerr  [NJ];
    logic [MAG_W-1:0]             max01;
    logic [MAG_W-1:0]             max23;
    logic [MAG_W-1:0]             max45;

    // Stage 1: error = goal - angle at 17 bits, then magnitude
    always_comb begin
        for (int l = 0; l < NJ; l++) begin
            err[l]  = {cfg.goal[l][ANGLE_W-1], cfg.goal[l]}
                    - {in_angle[l][ANGLE_W-1], in_angle[l]};
            nerr[l] = ERR_W'(0) - err[l];
            neg1_next[l] = err[l][ERR_W-1];
            mag1_next[l] = err[l][ERR_W-1] ? nerr[l][MAG_W-1:0] : err[l][MAG_W-1:0];
        end
    end

    // Stage 2: max tree, products, deadband
    always_comb begin
        max01 = max_mag(mag1_reg[0], mag1_reg[1]);
        max23 = max_mag(mag1_reg[2], mag1_reg[3]);
        max45 = max_mag(mag1_reg[4], mag1_reg[5]);
        ctl2_next.divisor = max_mag(max_mag(max01, max23), max45);
        ctl2_next.neg     = neg1_reg;
        for (int l = 0; l < NJ; l++) begin
            prod2_next[l]     = PROD_W'(mag1_reg[l]) * PROD_W'(cfg.max_speed);
            ctl2_next.live[l] = mag1_reg[l] > MAG_W'(cfg.deadband);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else if (adv) begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag1_reg  <= mag1_next;
            neg1_reg  <= neg1_next;
            prod2_reg <= prod2_next;
            ctl2_reg  <= ctl2_next;
        end
    end

    assign out_valid = valid2_reg;
    assign out_prod  = prod2_reg;
    assign out_ctl   = ctl2_reg;

endmodule

[hw/rtl/jvs_div_stage.sv]
`timescale 1ns / 1ps
// ============================================================================
// jvs_div_stage
// One registered slice of the restoring divider: settles a few quotient
// bits for all six joints, starting at FIRST_BIT.
// ============================================================================
module jvs_div_stage
    import jvs_pkg::*;
#(
    parameter int FIRST_BIT = QUO_W - 1
)
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     adv,
    input  logic     in_valid,
    input  rem_vec_t in_rem,
    input  quo_vec_t in_quo,
    input  div_ctl_t in_ctl,
    output logic     out_valid,
    output rem_vec_t out_rem,
    output quo_vec_t out_quo,
    output div_ctl_t out_ctl
);

    logic     valid_reg;
    rem_vec_t rem_reg;
    rem_vec_t rem_next;
    quo_vec_t quo_reg;
    quo_vec_t quo_next;
    div_ctl_t ctl_reg;

    // Compare-subtract of the shifted divisor, one quotient bit per step
    always_comb begin
        logic [PROD_W-1:0] trial;
        rem_next = in_rem;
        quo_next = in_quo;
        trial    = '0;
        for (int l = 0; l < NJ; l++) begin
            for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
                if (FIRST_BIT - j >= 0) begin
                    trial = PROD_W'(in_ctl.divisor) << (FIRST_BIT - j);
                    if (rem_next[l] >= trial) begin
                        rem_next[l] = rem_next[l] - trial;
                        quo_next[l][FIRST_BIT - j] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            ctl_reg <= in_ctl;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_ctl   = ctl_reg;

endmodule

[hw/rtl/jvs_out.sv]
`timescale 1ns / 1ps
// ============================================================================
// jvs_out
// Output register: restores the sign, applies the deadband and forms the
// all-stopped flag.
// ============================================================================
module jvs_out
    import jvs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       adv,
    input  logic       in_valid,
    input  quo_vec_t   in_quo,
    input  div_ctl_t   in_ctl,
    output logic       out_valid,
    output speed_vec_t out_speed,
    output logic       out_all_stopped
);

    logic       valid_reg;
    speed_vec_t speed_reg;
    speed_vec_t speed_next;
    logic       stopped_reg;
    logic       stopped_next;

    // Quotient of a live joint never exceeds max_speed, so the 16-bit result needs no clamp
    always_comb begin
        stopped_next = 1'b1;
        for (int l = 0; l < NJ; l++) begin
            if (!in_ctl.live[l]) begin
                speed_next[l] = '0;
            end else if (in_ctl.neg[l]) begin
                speed_next[l] = SPEED_W'(0) - SPEED_W'(in_quo[l]);
            end else begin
                speed_next[l] = SPEED_W'(in_quo[l]);
            end
            if (speed_next[l] != '0) begin
                stopped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            speed_reg   <= speed_next;
            stopped_reg <= stopped_next;
        end
    end

    assign out_valid       = valid_reg;
    assign out_speed       = speed_reg;
    assign out_all_stopped = stopped_reg;

endmodule

[hw/rtl/joint_velocity_scaler.sv]
`timescale 1ns / 1ps
`include "joint_velocity_scaler_assert.svh"
// ============================================================================
// joint_velocity_scaler
// Normalized joint-space velocity command for a six-joint arm.
// ============================================================================
// Takes one transaction of six measured joint angles per clock, unless the
// pipeline is stalled, and returns six commanded speeds plus an all-stopped
// flag. The result of an accepted transaction passes through eight register
// stages: one for the errors, one for the largest error and the scaled
// products, five stages of the divider (three quotient bits each) and the
// output register. The pipeline holds up to 8 transactions. It advances as a
// whole whenever the output register is empty or being taken, so s_ready
// follows m_ready while a result is waiting. Goal angles, max speed and
// deadband must only be written while no transaction is in flight.
module joint_velocity_scaler
    import jvs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,

    // Input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [ANGLE_W-1:0] s_angle_0,
    input  logic signed [ANGLE_W-1:0] s_angle_1,
    input  logic signed [ANGLE_W-1:0] s_angle_2,
    input  logic signed [ANGLE_W-1:0] s_angle_3,
    input  logic signed [ANGLE_W-1:0] s_angle_4,
    input  logic signed [ANGLE_W-1:0] s_angle_5,

    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [SPEED_W-1:0] m_speed_0,
    output logic signed [SPEED_W-1:0] m_speed_1,
    output logic signed [SPEED_W-1:0] m_speed_2,
    output logic signed [SPEED_W-1:0] m_speed_3,
    output logic signed [SPEED_W-1:0] m_speed_4,
    output logic signed [SPEED_W-1:0] m_speed_5,
    output logic                  m_all_stopped
);

    cfg_t       cfg_q;
    logic       adv;
    angle_vec_t angle_vec;
    speed_vec_t speed_vec;

    logic       vld_bus [DIV_STAGES+1];
    rem_vec_t   rem_bus [DIV_STAGES+1];
    quo_vec_t   quo_bus [DIV_STAGES+1];
    div_ctl_t   ctl_bus [DIV_STAGES+1];

    // Whole pipeline moves when the output register can take a transaction
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    assign angle_vec = {s_angle_5, s_angle_4, s_angle_3, s_angle_2, s_angle_1, s_angle_0};

    jvs_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg_o        (cfg_q)
    );

    jvs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_angle  (angle_vec),
        .cfg       (cfg_q),
        .out_valid (vld_bus[0]),
        .out_prod  (rem_bus[0]),
        .out_ctl   (ctl_bus[0])
    );

    assign quo_bus[0] = '0;

    // Divider slices, most significant quotient bits first
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        jvs_div_stage #(
            .FIRST_BIT (QUO_W - 1 - s * DIV_BITS_PER_STAGE)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (vld_bus[s]),
            .in_rem    (rem_bus[s]),
            .in_quo    (quo_bus[s]),
            .in_ctl    (ctl_bus[s]),
            .out_valid (vld_bus[s+1]),
            .out_rem   (rem_bus[s+1]),
            .out_quo   (quo_bus[s+1]),
            .out_ctl   (ctl_bus[s+1])
        );
    end

    jvs_out u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .adv             (adv),
        .in_valid        (vld_bus[DIV_STAGES]),
        .in_quo          (quo_bus[DIV_STAGES]),
        .in_ctl          (ctl_bus[DIV_STAGES]),
        .out_valid       (m_valid),
        .out_speed       (speed_vec),
        .out_all_stopped (m_all_stopped)
    );

    assign m_speed_0 = speed_vec[0];
    assign m_speed_1 = speed_vec[1];
    assign m_speed_2 = speed_vec[2];
    assign m_speed_3 = speed_vec[3];
    assign m_speed_4 = speed_vec[4];
    assign m_speed_5 = speed_vec[5];

    // Assertions

    // Divider leaves a remainder below the divisor for joint 0 when it is live
    `JVS_ASSERT_IMPL(a_div_rem_range, aclk, aresetn,
        vld_bus[DIV_STAGES] && ctl_bus[DIV_STAGES].live[0],
        rem_bus[DIV_STAGES][0] < PROD_W'(ctl_bus[DIV_STAGES].divisor),
        "divider remainder not below divisor")

    // A stall freezes the last divider slice
    `JVS_ASSERT_NEXT(a_stall_holds, aclk, aresetn,
        !adv,
        $stable(vld_bus[DIV_STAGES]) && $stable(quo_bus[DIV_STAGES]),
        "pipeline moved during a stall")

    // Flag matches the speeds delivered
    `JVS_ASSERT_IMPL(a_stopped_flag, aclk, aresetn,
        m_valid,
        m_all_stopped == (speed_vec == '0),
        "all_stopped disagrees with speeds")

    // A positive speed on joint 0 never exceeds max_speed
    `JVS_ASSERT_IMPL(a_speed_bound, aclk, aresetn,
        m_valid && !m_speed_0[SPEED_W-1],
        $unsigned(m_speed_0) <= {1'b0, cfg_q.max_speed},
        "speed above max_speed")

endmodule

[verif/tb_joint_velocity_scaler.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_joint_velocity_scaler
// Self-checking testbench for the joint velocity scaler. A local predictor
// computes the scaled joint speeds of every accepted angle transaction; a
// result monitor compares each returned transaction, field by field, with
// the oldest pending prediction. Covers reset values, deadband edges, error
// extremes, truncation to zero, back-pressure and random configurations.
// ============================================================================
module tb_joint_velocity_scaler;
    import jvs_pkg::*;

    localparam int DRAIN_CYCLES = 16;   // pipeline depth is 8, with margin
    localparam int MAX_PRINTED  = 40;

    typedef struct {
        speed_vec_t speed;
        logic       all_stopped;
    } speed_cmd_t;

    // DUT signals
    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_wr_index  = '0;
    logic [CFG_DATA_W-1:0]    cfg_wr_data   = '0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic signed [ANGLE_W-1:0] s_angle [NJ] = '{default: '0};
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic signed [SPEED_W-1:0] m_speed [NJ];
    logic                     m_all_stopped;

    // Shadow of the configuration registers
    logic signed [ANGLE_W-1:0] goal_q [NJ] = '{default: '0};
    logic [SPD_CFG_W-1:0]     max_speed_q  = MAX_SPEED_RST;
    logic [SPD_CFG_W-1:0]     deadband_q   = DEADBAND_RST;

    speed_cmd_t               speed_cmd_q [$];
    int                       error_count      = 0;
    bit                       idle_on          = 1'b1;
    int                       sink_hold_cycles = 0;

    joint_velocity_scaler dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_angle_0     (s_angle[0]),
        .s_angle_1     (s_angle[1]),
        .s_angle_2     (s_angle[2]),
        .s_angle_3     (s_angle[3]),
        .s_angle_4     (s_angle[4]),
        .s_angle_5     (s_angle[5]),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_speed_0     (m_speed[0]),
        .m_speed_1     (m_speed[1]),
        .m_speed_2     (m_speed[2]),
        .m_speed_3     (m_speed[3]),
        .m_speed_4     (m_speed[4]),
        .m_speed_5     (m_speed[5]),
        .m_all_stopped (m_all_stopped)
    );

    // Clock
    always #5 aclk = ~aclk;

    // Watchdog
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED) begin
            $display("ERROR %0t ns: %s", $time, msg);
        end
        error_count++;
    endtask

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic angle_vec_t angles_of(input int a0, input int a1, input int a2,
                                             input int a3, input int a4, input int a5);
        angle_vec_t v;
        v[0] = ANGLE_W'(a0);
        v[1] = ANGLE_W'(a1);
        v[2] = ANGLE_W'(a2);
        v[3] = ANGLE_W'(a3);
        v[4] = ANGLE_W'(a4);
        v[5] = ANGLE_W'(a5);
        return v;
    endfunction

    // Expected speeds: scale every error by max_speed / largest |error|
    function automatic speed_cmd_t predict_speed_cmd(input angle_vec_t a);
        logic signed [ERR_W-1:0] err [NJ];
        logic [MAG_W-1:0]        mag [NJ];
        logic [MAG_W-1:0]        largest;
        longint                  scaled;
        speed_cmd_t              cmd;
        largest = '0;
        for (int j = 0; j < NJ; j++) begin
            err[j] = $signed({goal_q[j][ANGLE_W-1], goal_q[j]})
                   - $signed({a[j][ANGLE_W-1], a[j]});
            mag[j] = MAG_W'(err[j] < 0 ? -err[j] : err[j]);
            if (mag[j] > largest) largest = mag[j];
        end
        cmd.all_stopped = 1'b1;
        for (int j = 0; j < NJ; j++) begin
            scaled = 0;
            // joints inside the deadband stay at zero; no divide when all errors are 0
            if (mag[j] > deadband_q && largest != 0) begin
                scaled = (longint'(mag[j]) * longint'(max_speed_q)) / longint'(largest);
                if (err[j] < 0) scaled = -scaled;
                if (scaled > 32767) scaled = 32767;
                if (scaled < -32768) scaled = -32768;
            end
            cmd.speed[j] = SPEED_W'(scaled);
            if (scaled != 0) cmd.all_stopped = 1'b0;
        end
        return cmd;
    endfunction

    // Random angle, often placed near the goal so the deadband edge is hit
    function automatic logic [ANGLE_W-1:0] random_angle(input int j);
        int base;
        int band;
        base = int'(goal_q[j]);
        band = int'(deadband_q);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return ANGLE_W'($urandom);
            4, 5, 6:    return ANGLE_W'(base + int'($urandom_range(0, 2 * band + 8)) - band - 4);
            7:          return ANGLE_W'(base + int'($urandom_range(0, 40)) - 20);
            8: begin
                case ($urandom_range(0, 2))
                    0:       return 16'h7FFF;
                    1:       return 16'h8000;
                    default: return '0;
                endcase
            end
            default: begin
                if ($urandom_range(0, 1) != 0) return ANGLE_W'(base + band + int'($urandom_range(0, 1)));
                return ANGLE_W'(base - band - int'($urandom_range(0, 1)));
            end
        endcase
    endfunction

    // Write all eight registers; bit 15 of the data for the speed registers is junk
    task automatic apply_config(input angle_vec_t goals, input logic [SPD_CFG_W-1:0] spd,
                                input logic [SPD_CFG_W-1:0] band);
        for (int j = 0; j < NJ; j++) begin
            cfg_wr_en    <= 1'b1;
            cfg_wr_index <= cfg_index_t'(int'(CFG_GOAL_ANGLE_0) + j);
            cfg_wr_data  <= goals[j];
            goal_q[j]     = goals[j];
            @(posedge aclk);
        end
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= CFG_MAX_SPEED;
        cfg_wr_data  <= {1'($urandom), spd};
        max_speed_q   = spd;
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= CFG_DEADBAND;
        cfg_wr_data  <= {1'($urandom), band};
        deadband_q    = band;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    // Offer one angle transaction and log its prediction once accepted
    task automatic send_angles(input angle_vec_t a);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        for (int j = 0; j < NJ; j++) s_angle[j] <= a[j];
        do @(posedge aclk); while (s_ready !== 1'b1);
        speed_cmd_q.push_back(predict_speed_cmd(a));
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (speed_cmd_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic check_speed_cmd();
        speed_cmd_t exp_cmd;
        if (speed_cmd_q.size() == 0) begin
            report_mismatch("result transaction with nothing pending");
            return;
        end
        exp_cmd = speed_cmd_q.pop_front();
        for (int j = 0; j < NJ; j++) begin
            if (m_speed[j] !== exp_cmd.speed[j]) begin
                report_mismatch($sformatf("speed_%0d: expected %0d, got %0d", j,
                                          $signed(exp_cmd.speed[j]), m_speed[j]));
            end
        end
        if (m_all_stopped !== exp_cmd.all_stopped) begin
            report_mismatch($sformatf("all_stopped: expected %0b, got %0b",
                                      exp_cmd.all_stopped, m_all_stopped));
        end
    endtask

    // Result side: check on every handshake, then pick the next ready value
    initial begin : result_sink
        int gap_left;
        gap_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) check_speed_cmd();
            if (sink_hold_cycles > 0) begin
                sink_hold_cycles--;
                m_ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (idle_on) gap_left = pick_gap();
            end
        end
    end

    // Registers still at reset: zero goals, default speed and deadband
    task automatic test_reset_values();
        send_angles(angles_of(0, 0, 0, 0, 0, 0));
        send_angles(angles_of(-82, 82, -83, 83, 0, 1000));
        send_angles(angles_of(32767, -32768, 0, 1, -1, 4096));
        wait_for_results();
    endtask

    // Extremes of errors and registers, deadband edges, truncation to zero
    task automatic test_special_cases();
        apply_config(angles_of(32767, 32767, 32767, 32767, 32767, 32767), 15'h7FFF, 15'd0);
        send_angles(angles_of(-32768, -32768, -32768, -32768, -32768, -32768));
        send_angles(angles_of(-32768, 32767, 0, 32766, -1, 1));
        wait_for_results();

        apply_config(angles_of(-32768, -32768, -32768, -32768, -32768, -32768),
                     15'h7FFF, 15'h7FFF);
        send_angles(angles_of(32767, 32767, 32767, 32767, 32767, 32767));
        send_angles(angles_of(32767, 0, -1, -32768, 1, -32767));
        wait_for_results();

        // max_speed of zero: every joint outside the deadband still stops
        apply_config(angles_of(0, 0, 0, 0, 0, 0), 15'd0, 15'd10);
        send_angles(angles_of(1000, -2000, 30000, -32768, 32767, 11));
        wait_for_results();

        // tiny max_speed: smaller errors truncate to zero outside the deadband
        apply_config(angles_of(0, 0, 0, 0, 0, 0), 15'd1, 15'd0);
        send_angles(angles_of(-1000, -999, -1, 0, 500, 1000));
        send_angles(angles_of(0, 0, 0, 0, 0, 0));
        send_angles(angles_of(0, 0, 0, 0, 0, -1));
        wait_for_results();

        // deadband edge with mixed goals
        apply_config(angles_of(100, -100, 2000, -2000, 0, 32767), 15'd12861, 15'd100);
        send_angles(angles_of(0, 0, 1900, -1899, 100, 32667));
        send_angles(angles_of(200, -200, 2101, -2101, -101, 32666));
        wait_for_results();
    endtask

    // Receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure();
        angle_vec_t a;
        idle_on          = 1'b0;
        sink_hold_cycles = 60;
        for (int n = 0; n < 30; n++) begin
            for (int j = 0; j < NJ; j++) a[j] = random_angle(j);
            send_angles(a);
        end
        wait_for_results();
        idle_on = 1'b1;
    endtask

    // Random configurations, each followed by a burst of random angles
    task automatic test_random_traffic(input int phases, input int per_phase);
        angle_vec_t           goals;
        angle_vec_t           a;
        logic [SPD_CFG_W-1:0] spd;
        logic [SPD_CFG_W-1:0] band;
        for (int p = 0; p < phases; p++) begin
            for (int j = 0; j < NJ; j++) begin
                case ($urandom_range(0, 4))
                    0:       goals[j] = 16'h7FFF;
                    1:       goals[j] = 16'h8000;
                    2:       goals[j] = '0;
                    default: goals[j] = ANGLE_W'($urandom);
                endcase
            end
            case ($urandom_range(0, 9))
                0:       spd = '0;
                1:       spd = 15'h7FFF;
                2:       spd = SPD_CFG_W'($urandom_range(1, 64));
                default: spd = SPD_CFG_W'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0:          band = '0;
                1:          band = 15'h7FFF;
                2, 3, 4, 5: band = SPD_CFG_W'($urandom_range(0, 300));
                default:    band = SPD_CFG_W'($urandom);
            endcase
            apply_config(goals, spd, band);
            // every third phase runs with no idling on either side
            idle_on = (p % 3) != 0;
            for (int n = 0; n < per_phase; n++) begin
                for (int j = 0; j < NJ; j++) a[j] = random_angle(j);
                send_angles(a);
            end
            wait_for_results();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_special_cases();
        test_backpressure();
        test_random_traffic(10, 48);

        wait_for_results();
        if (error_count == 0 && speed_cmd_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
